// ===== sv/obs_pkg.sv =====
// ----------------------------------------------------------------------------
// obs_pkg: shared definitions for the orthogonal block scheduler
// Request codes, status codes, register indexes, field widths and the
// sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package obs_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;
  localparam int CFG_W    = 5;
  localparam int REG_IDX_W = 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_EPOCH   = 2'd2,
    ACT_INIT    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_GRANTED  = 3'd0,
    STS_ALL_OUT  = 3'd1,
    STS_NONE_NOW = 3'd2,
    STS_ACCEPTED = 3'd3,
    STS_BAD_ID   = 3'd4
  } status_t;

  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] GRID_RESET = 5'd4;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_SCAN_ADDR = 4'b0010,
    ST_SCAN_TEST = 4'b0100,
    ST_REL_DIV   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== sv/obs_ram.sv =====
// ----------------------------------------------------------------------------
// obs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module obs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/obs_div.sv =====
// ----------------------------------------------------------------------------
// obs_div: iterative restoring divider
// Splits a block number into grid row (quotient) and grid column
// (remainder), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module obs_div
  import obs_pkg::*;
#(
  parameter int DIVISOR_W = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [ID_W-1:0]      dividend,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output logic                      done,
  output logic [ID_W-1:0]           quotient,
  output logic [DIVISOR_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(ID_W + 1);

  logic                 run;
  logic [CNT_W-1:0]     cnt;
  logic [ID_W-1:0]      dq;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W:0]   rem_step;

  always_comb begin
    trial    = {rem, dq[ID_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_step = ge ? (trial - {1'b0, divisor}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(ID_W);
      dq  <= dividend;
      rem <= '0;
    end else if (run) begin
      // shift in one quotient bit, keep the partial remainder
      cnt <= cnt - CNT_W'(1);
      dq  <= {dq[ID_W-2:0], ge};
      rem <= rem_step[DIVISOR_W-1:0];
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== sv/orthogonal_block_scheduler.sv =====
// ----------------------------------------------------------------------------
// orthogonal_block_scheduler: hands out grid blocks with no shared row/column
// Request, release, next-epoch and initialize commands on a start/busy port;
// one result per command, shown for one cycle under done.
// ----------------------------------------------------------------------------
// Usage: issue a command by raising start while busy is low; exactly one
// result follows, held on the result ports for a single cycle under done,
// and the receiver has no way to hold it off, so capture it that cycle.
// Next-epoch, initialize, a release with a bad id and a request with no
// blocks left answer in the cycle after the command without raising busy.
// A good release waits for the one-bit-per-cycle divider that splits the
// 8-bit block number into row and column. A request tests grid cells one
// at a time, each through an address state and a test state, using a
// single cell-test unit behind the registered read port of the epoch
// table, and answers none-free once the scan runs past the last diagonal
// or its step limit. Epoch table entries are reset by per-entry valid
// flags, so no clearing pass follows reset or initialize. Grid registers
// may be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module orthogonal_block_scheduler
  import obs_pkg::*;
#(
  parameter int MAX_GRID_COLS = 16,
  parameter int MAX_GRID_ROWS = 16,
  parameter int EPOCH_BITS    = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  input  wire logic                 start,
  input  wire logic [ACTION_W-1:0]  action,
  input  wire logic [ID_W-1:0]      block_id,
  output logic                      busy,
  output logic                      done,
  output logic [STATUS_W-1:0]       status,
  output logic [ID_W-1:0]           granted_block,
  output logic [COUNT_W-1:0]        blocks_left,
  output logic [COUNT_W-1:0]        blocks_done
);

  localparam int CELLS      = MAX_GRID_ROWS * MAX_GRID_COLS;
  localparam int CW         = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
  localparam int RW         = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int CFW        = $clog2(MAX_GRID_COLS + 1);
  localparam int RFW        = $clog2(MAX_GRID_ROWS + 1);
  localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CELLS_CW   = $clog2(CELLS + 1);
  localparam int LEFT_W     = $clog2(((CELLS > 16) ? CELLS : 16) + 1);
  localparam int SCAN_LIMIT = (MAX_GRID_ROWS + 2) * (MAX_GRID_COLS + 2);
  localparam int IT_W       = $clog2(SCAN_LIMIT + 1);
  localparam int LEFT_RESET = 16;

  state_t state, state_next;

  logic [CFW-1:0]           grid_cols;
  logic [RFW-1:0]           grid_rows;
  logic [CFG_W-1:0]         cols_reg, rows_reg;
  logic [CELLS_CW-1:0]      cells_eff;

  logic [MAX_GRID_COLS-1:0] busy_cols, busy_cols_next;
  logic [MAX_GRID_ROWS-1:0] busy_rows, busy_rows_next;
  logic [CELLS-1:0]         vld, vld_next;
  logic [EPOCH_BITS-1:0]    epoch_now, epoch_now_next;
  logic [CW-1:0]            scan_col, scan_col_next;
  logic [RW-1:0]            scan_row, scan_row_next;
  logic [CFW-1:0]           diagonal, diagonal_next;
  logic [LEFT_W-1:0]        left_count, left_count_next;
  logic [CELLS_CW-1:0]      done_count, done_count_next;

  logic [CFW-1:0]           x, x_next;
  logic [RFW-1:0]           y, y_next;
  logic [CFW-1:0]           d, d_next;
  logic [IT_W-1:0]          it, it_next;
  logic                     tst_free, tst_free_next;
  logic                     tst_vld, tst_vld_next;
  logic [CELL_W-1:0]        tst_id, tst_id_next;
  logic                     rel_vld, rel_vld_next;
  logic [CELL_W-1:0]        rel_id, rel_id_next;

  logic                     done_next;
  logic [STATUS_W-1:0]      status_next;
  logic [ID_W-1:0]          granted_next;

  logic                     ram_wr_en, ram_rd_en;
  logic [CELL_W-1:0]        ram_wr_addr, ram_rd_addr;
  logic [EPOCH_BITS-1:0]    ram_wr_data, ram_rd_data;

  logic                     div_start, div_done;
  logic [ID_W-1:0]          div_quo;
  logic [CFW-1:0]           div_rem;

  logic [RFW+CFW-1:0]       row_base;
  logic [RFW+CFW:0]         cell_sum;
  logic [CELL_W-1:0]        cell_addr;
  logic                     in_grid;
  logic [CFW:0]             x_inc;
  logic [RFW:0]             y_inc;
  logic [CFW:0]             d_inc;
  logic [EPOCH_BITS-1:0]    ep_seen;
  logic                     accept;

  // clamp the grid registers into 1..MAX
  always_comb begin
    if (cols_reg == '0) begin
      grid_cols = CFW'(1);
    end else if (32'(cols_reg) > MAX_GRID_COLS) begin
      grid_cols = CFW'(MAX_GRID_COLS);
    end else begin
      grid_cols = CFW'(cols_reg);
    end
    if (rows_reg == '0) begin
      grid_rows = RFW'(1);
    end else if (32'(rows_reg) > MAX_GRID_ROWS) begin
      grid_rows = RFW'(MAX_GRID_ROWS);
    end else begin
      grid_rows = RFW'(rows_reg);
    end
    cells_eff = CELLS_CW'(grid_rows) * CELLS_CW'(grid_cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= GRID_RESET;
      rows_reg <= GRID_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_GRID_COLS) begin
        cols_reg <= wr_data;
      end
      if (wr_index == REG_GRID_ROWS) begin
        rows_reg <= wr_data;
      end
    end
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // cell test unit: address of the current scan cell, its in-grid flag and the step increments
  always_comb begin
    row_base  = (RFW+CFW)'(y) * (RFW+CFW)'(grid_cols);
    cell_sum  = {1'b0, row_base} + (RFW+CFW+1)'(x);
    cell_addr = CELL_W'(cell_sum);
    in_grid   = (x < grid_cols) && (y < grid_rows);
    x_inc     = {1'b0, x} + (CFW+1)'(1);
    y_inc     = {1'b0, y} + (RFW+1)'(1);
    d_inc     = {1'b0, d} + (CFW+1)'(1);
  end

  always_comb begin
    state_next      = state;
    busy_cols_next  = busy_cols;
    busy_rows_next  = busy_rows;
    vld_next        = vld;
    epoch_now_next  = epoch_now;
    scan_col_next   = scan_col;
    scan_row_next   = scan_row;
    diagonal_next   = diagonal;
    left_count_next = left_count;
    done_count_next = done_count;
    x_next          = x;
    y_next          = y;
    d_next          = d;
    it_next         = it;
    tst_free_next   = tst_free;
    tst_vld_next    = tst_vld;
    tst_id_next     = tst_id;
    rel_vld_next    = rel_vld;
    rel_id_next     = rel_id;
    done_next       = 1'b0;
    status_next     = STS_ACCEPTED;
    granted_next    = '0;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = rel_id;
    ram_wr_data     = '0;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = cell_addr;
    div_start       = 1'b0;
    ep_seen         = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_REQUEST: begin
              if (left_count == '0) begin
                done_next   = 1'b1;
                status_next = STS_ALL_OUT;
              end else begin
                x_next     = CFW'(scan_col);
                y_next     = RFW'(scan_row);
                d_next     = diagonal;
                it_next    = '0;
                state_next = ST_SCAN_ADDR;
              end
            end
            ACT_RELEASE: begin
              if (32'(block_id) >= 32'(cells_eff) || 32'(block_id) >= CELLS) begin
                done_next   = 1'b1;
                status_next = STS_BAD_ID;
              end else begin
                rel_id_next  = CELL_W'(block_id);
                rel_vld_next = vld[CELL_W'(block_id)];
                ram_rd_en    = 1'b1;
                ram_rd_addr  = CELL_W'(block_id);
                div_start    = 1'b1;
                state_next   = ST_REL_DIV;
              end
            end
            ACT_EPOCH: begin
              epoch_now_next  = epoch_now + EPOCH_BITS'(1);
              left_count_next = LEFT_W'(cells_eff);
              done_count_next = '0;
              scan_col_next   = '0;
              scan_row_next   = '0;
              diagonal_next   = '0;
              done_next       = 1'b1;
            end
            ACT_INIT: begin
              vld_next        = '0;
              epoch_now_next  = EPOCH_BITS'(1);
              busy_cols_next  = '0;
              busy_rows_next  = '0;
              left_count_next = LEFT_W'(cells_eff);
              done_count_next = '0;
              scan_col_next   = '0;
              scan_row_next   = '0;
              diagonal_next   = '0;
              done_next       = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN_ADDR: begin
        if (d >= grid_cols || 32'(it) >= SCAN_LIMIT) begin
          // ran past the last diagonal or the scan limit: keep the scan start
          done_next   = 1'b1;
          status_next = STS_NONE_NOW;
          state_next  = ST_IDLE;
        end else begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = cell_addr;
          tst_id_next   = cell_addr;
          tst_vld_next  = vld[cell_addr];
          tst_free_next = in_grid && !busy_cols[x[CW-1:0]] && !busy_rows[y[RW-1:0]];
          state_next    = ST_SCAN_TEST;
        end
      end

      ST_SCAN_TEST: begin
        ep_seen = tst_vld ? ram_rd_data : EPOCH_BITS'(1);
        if (tst_free && ep_seen == epoch_now) begin
          busy_cols_next[x[CW-1:0]] = 1'b1;
          busy_rows_next[y[RW-1:0]] = 1'b1;
          left_count_next = left_count - LEFT_W'(1);
          scan_col_next   = x[CW-1:0];
          scan_row_next   = y[RW-1:0];
          diagonal_next   = d;
          done_next       = 1'b1;
          status_next     = STS_GRANTED;
          granted_next    = ID_W'(tst_id);
          state_next      = ST_IDLE;
        end else begin
          // advance along the diagonal, wrapping to the next one
          it_next = it + IT_W'(1);
          if (y_inc >= (RFW+1)'(grid_rows)) begin
            d_next = CFW'(d_inc);
            x_next = CFW'(d_inc);
            y_next = '0;
          end else if (x_inc >= (CFW+1)'(grid_cols)) begin
            x_next = '0;
            y_next = RFW'(y_inc);
          end else begin
            x_next = CFW'(x_inc);
            y_next = RFW'(y_inc);
          end
          state_next = ST_SCAN_ADDR;
        end
      end

      ST_REL_DIV: begin
        if (div_done) begin
          ep_seen     = rel_vld ? ram_rd_data : EPOCH_BITS'(1);
          ram_wr_en   = 1'b1;
          ram_wr_addr = rel_id;
          ram_wr_data = ep_seen + EPOCH_BITS'(1);
          vld_next[rel_id] = 1'b1;
          busy_cols_next[div_rem[CW-1:0]] = 1'b0;
          busy_rows_next[RW'(div_quo)]    = 1'b0;
          if (done_count < cells_eff) begin
            done_count_next = done_count + CELLS_CW'(1);
          end
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      busy_cols  <= '0;
      busy_rows  <= '0;
      vld        <= '0;
      epoch_now  <= EPOCH_BITS'(1);
      scan_col   <= '0;
      scan_row   <= '0;
      diagonal   <= '0;
      left_count <= LEFT_W'(LEFT_RESET);
      done_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      busy_cols  <= busy_cols_next;
      busy_rows  <= busy_rows_next;
      vld        <= vld_next;
      epoch_now  <= epoch_now_next;
      scan_col   <= scan_col_next;
      scan_row   <= scan_row_next;
      diagonal   <= diagonal_next;
      left_count <= left_count_next;
      done_count <= done_count_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    x        <= x_next;
    y        <= y_next;
    d        <= d_next;
    it       <= it_next;
    tst_free <= tst_free_next;
    tst_vld  <= tst_vld_next;
    tst_id   <= tst_id_next;
    rel_vld  <= rel_vld_next;
    rel_id   <= rel_id_next;
    if (done_next) begin
      status        <= status_next;
      granted_block <= granted_next;
      blocks_left   <= COUNT_W'(left_count_next);
      blocks_done   <= COUNT_W'(done_count_next);
    end
  end

  obs_ram #(
    .WIDTH (EPOCH_BITS),
    .DEPTH (CELLS)
  ) u_epoch_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  obs_div #(
    .DIVISOR_W (CFW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (block_id),
    .divisor   (grid_cols),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

endmodule

`default_nettype wire

// ===== sv/obs_checker.sv =====
// ----------------------------------------------------------------------------
// obs_checker: port-level checks for the orthogonal block scheduler
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module obs_checker
  import obs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [ID_W-1:0]     granted_block
);

  // an accepted command either answers at once or holds the port busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither answered nor went busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STS_GRANTED) |-> (granted_block == '0))
    else $error("block number shown without a grant");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("activity right after reset");

endmodule

bind orthogonal_block_scheduler obs_checker u_obs_checker (.*);

`default_nettype wire
